// ===== rtl/msp_pkg.sv =====
package msp_pkg;

    localparam logic [7:0] REALTIME_MASK = 8'hF8;
    localparam logic [7:0] SYSTEM_MASK   = 8'hF0;
    localparam logic [7:0] STATUS_FLAG   = 8'h80;
    localparam logic [7:0] CHANNEL_MASK  = 8'h0F;

    localparam logic [3:0] KIND_NOTE_OFF      = 4'h8;
    localparam logic [3:0] KIND_NOTE_ON       = 4'h9;
    localparam logic [3:0] KIND_PROG_CHANGE   = 4'hC;
    localparam logic [3:0] KIND_CHAN_PRESSURE = 4'hD;

    typedef struct packed {
        logic [7:0] running_status;
        logic       pending;
        logic [6:0] first_data;
    } parser_state_t;

    typedef struct packed {
        logic       valid;
        logic [7:0] status;
        logic [6:0] data1;
        logic [6:0] data2;
    } parser_msg_t;

endpackage

// ===== rtl/msp_decode.sv =====
module msp_decode (
    input  logic [7:0]             in_byte,
    input  logic [3:0]             rx_channel,
    input  msp_pkg::parser_state_t state_cur,
    output msp_pkg::parser_state_t state_next,
    output msp_pkg::parser_msg_t   msg
);
    import msp_pkg::*;

    logic [3:0] kind;
    logic [3:0] channel;
    logic [6:0] data_in;
    logic       chan_match;
    logic       one_data;

    assign kind       = state_cur.running_status[7:4];
    assign channel    = state_cur.running_status[3:0];
    assign data_in    = in_byte[6:0];
    assign chan_match = (channel == rx_channel);
    assign one_data   = kind inside {KIND_PROG_CHANGE, KIND_CHAN_PRESSURE};

    always_comb
    begin
        state_next = state_cur;
        msg        = '0;
        if ((in_byte & STATUS_FLAG) != 8'h00)
        begin
            if ((in_byte & REALTIME_MASK) == REALTIME_MASK)
            begin
                // pass real-time straight through
                msg.valid  = 1'b1;
                msg.status = in_byte;
            end
            else if ((in_byte & SYSTEM_MASK) == SYSTEM_MASK)
            begin
                state_next.running_status = 8'h00;
                state_next.pending        = 1'b0;
            end
            else
            begin
                state_next.running_status = in_byte;
                state_next.pending        = 1'b0;
            end
        end
        else if (state_cur.running_status != 8'h00)
        begin
            if (one_data)
            begin
                state_next.pending = 1'b0;
                msg.valid          = chan_match;
                msg.status         = state_cur.running_status;
                msg.data1          = data_in;
            end
            else if (!state_cur.pending)
            begin
                state_next.first_data = data_in;
                state_next.pending    = 1'b1;
            end
            else
            begin
                state_next.pending = 1'b0;
                msg.valid          = chan_match;
                msg.data1          = state_cur.first_data;
                msg.data2          = data_in;
                if (kind == KIND_NOTE_ON && data_in == 7'd0)
                begin
                    msg.status = {KIND_NOTE_OFF, channel};
                end
                else
                begin
                    msg.status = state_cur.running_status;
                end
            end
        end
    end

endmodule

// ===== rtl/midi_stream_parser.sv =====
// Channel   Handshake              Payload
// input     in_valid / in_stall    in_byte
// output    out_valid / out_stall  msg_status, msg_data1, msg_data2
// config    cfg_wr_en              cfg_wr_data (receive channel)
//
// One byte a cycle sustained while the result is not stalled; an accepted
// byte waits in the input register, then goes through decode into the result
// register. Reset clears the running status and both valid flags. A stalled
// result holds the decode stage; the input register then stalls the source.
module midi_stream_parser (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_wr_en,
    input  logic [3:0] cfg_wr_data,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] in_byte,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] msg_status,
    output logic [6:0] msg_data1,
    output logic [6:0] msg_data2
);
    import msp_pkg::*;

    logic [3:0]    rx_channel_reg;
    logic          in_valid_reg;
    logic [7:0]    in_byte_reg;
    parser_state_t state_reg;
    parser_state_t state_next;
    parser_msg_t   msg_next;
    parser_msg_t   out_reg;
    logic          advance;

    msp_decode u_decode (
        .in_byte    (in_byte_reg),
        .rx_channel (rx_channel_reg),
        .state_cur  (state_reg),
        .state_next (state_next),
        .msg        (msg_next)
    );

    assign advance  = !(out_reg.valid && out_stall);
    assign in_stall = in_valid_reg && !advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rx_channel_reg <= 4'd0;
            in_valid_reg   <= 1'b0;
            in_byte_reg    <= 8'h00;
            out_reg        <= '0;
            state_reg      <= '0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                rx_channel_reg <= cfg_wr_data;
            end
            if (!in_stall)
            begin
                in_valid_reg <= in_valid;
                if (in_valid)
                begin
                    in_byte_reg <= in_byte;
                end
            end
            if (advance)
            begin
                out_reg.valid <= in_valid_reg && msg_next.valid;
                if (in_valid_reg)
                begin
                    state_reg      <= state_next;
                    out_reg.status <= msg_next.status;
                    out_reg.data1  <= msg_next.data1;
                    out_reg.data2  <= msg_next.data2;
                end
            end
        end
    end

    assign out_valid  = out_reg.valid;
    assign msg_status = out_reg.status;
    assign msg_data1  = out_reg.data1;
    assign msg_data2  = out_reg.data2;

endmodule

// ===== dv/midi_stream_parser_tb.sv =====
`timescale 1ns / 100ps

module midi_stream_parser_tb;

    import msp_pkg::*;

    localparam logic [3:0] KIND_PITCH_BEND    = 4'hE;
    localparam int LONG_HOLD    = 200;
    localparam int STUCK_LIMIT  = 2000;
    localparam int PHASES       = 8;
    localparam int PHASE_BYTES  = 125;

    typedef struct packed {
        logic [7:0] status;
        logic [6:0] data1;
        logic [6:0] data2;
    } midi_msg_t;

    class midi_msg_tracker;
        logic [3:0] rx_channel;
        logic [7:0] run_status;
        logic       second_pending;
        logic [6:0] held_data;
        midi_msg_t  expected_msgs[$];
        int         errors;

        function new();
            rx_channel     = 4'h0;
            run_status     = 8'h00;
            second_pending = 1'b0;
            held_data      = 7'h00;
            errors         = 0;
        endfunction

        function void set_channel(logic [3:0] ch);
            rx_channel = ch;
        endfunction

        function int pending();
            return expected_msgs.size();
        endfunction

        function void complete_msg(logic [6:0] d1, logic [6:0] d2);
            midi_msg_t m;
            if (run_status[3:0] != rx_channel)
                return;
            m.status = run_status;
            if (run_status[7:4] == KIND_NOTE_ON && d2 == 7'h00)
                m.status = {KIND_NOTE_OFF, run_status[3:0]};
            m.data1 = d1;
            m.data2 = d2;
            expected_msgs.push_back(m);
        endfunction

        function void note_byte(logic [7:0] b);
            midi_msg_t m;
            if ((b & STATUS_FLAG) != 8'h00)
            begin
                if ((b & REALTIME_MASK) == REALTIME_MASK)
                begin
                    m.status = b;
                    m.data1  = 7'h00;
                    m.data2  = 7'h00;
                    expected_msgs.push_back(m);
                end
                else if ((b & SYSTEM_MASK) == SYSTEM_MASK)
                begin
                    run_status     = 8'h00;
                    second_pending = 1'b0;
                end
                else
                begin
                    run_status     = b;
                    second_pending = 1'b0;
                end
            end
            else if (run_status != 8'h00)
            begin
                if (run_status[7:4] == KIND_PROG_CHANGE
                        || run_status[7:4] == KIND_CHAN_PRESSURE)
                begin
                    second_pending = 1'b0;
                    complete_msg(b[6:0], 7'h00);
                end
                else if (!second_pending)
                begin
                    held_data      = b[6:0];
                    second_pending = 1'b1;
                end
                else
                begin
                    second_pending = 1'b0;
                    complete_msg(held_data, b[6:0]);
                end
            end
        endfunction

        function void check_msg(logic [7:0] st, logic [6:0] d1, logic [6:0] d2);
            midi_msg_t want;
            if (expected_msgs.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected message, expected none, actual %h %h %h",
                         $time, st, d1, d2);
                return;
            end
            want = expected_msgs.pop_front();
            if (want.status !== st)
            begin
                errors++;
                $display("%0t: msg_status expected %h actual %h", $time, want.status, st);
            end
            if (want.data1 !== d1)
            begin
                errors++;
                $display("%0t: msg_data1 expected %h actual %h", $time, want.data1, d1);
            end
            if (want.data2 !== d2)
            begin
                errors++;
                $display("%0t: msg_data2 expected %h actual %h", $time, want.data2, d2);
            end
        endfunction
    endclass

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       cfg_wr_en = 1'b0;
    logic [3:0] cfg_wr_data = 4'h0;
    logic       in_valid = 1'b0;
    logic       in_stall;
    logic [7:0] in_byte = 8'h00;
    logic       out_valid;
    logic       out_stall = 1'b0;
    logic [7:0] msg_status;
    logic [6:0] msg_data1;
    logic [6:0] msg_data2;

    midi_msg_tracker board = new();

    bit         no_idle = 1'b0;
    bit         long_hold_req = 1'b0;
    int         stall_left = 0;
    int         stuck_cycles = 0;
    int         bytes_sent = 0;
    logic [7:0] last_status = 8'h00;

    midi_stream_parser dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .in_byte     (in_byte),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .msg_status  (msg_status),
        .msg_data1   (msg_data1),
        .msg_data2   (msg_data2)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    always @(negedge clk)
    begin
        if (stall_left > 0)
        begin
            out_stall <= 1'b1;
            stall_left--;
        end
        else if (long_hold_req)
        begin
            out_stall     <= 1'b1;
            stall_left    = LONG_HOLD - 1;
            long_hold_req = 1'b0;
        end
        else if (!no_idle && $urandom_range(0, 5) == 0)
        begin
            out_stall  <= 1'b1;
            stall_left = $urandom_range(0, 2);
        end
        else
            out_stall <= 1'b0;
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            board.check_msg(msg_status, msg_data1, msg_data2);
    end

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            stuck_cycles = 0;
        else
            stuck_cycles++;
        if (stuck_cycles >= STUCK_LIMIT)
        begin
            $display("midi_stream_parser regression: fail");
            $finish;
        end
    end

    task automatic send_byte(input logic [7:0] b);
        @(negedge clk);
        in_valid <= 1'b1;
        in_byte  <= b;
        do
            @(posedge clk);
        while (in_stall);
        board.note_byte(b);
    endtask

    task automatic idle_sender(input int n);
        @(negedge clk);
        in_valid <= 1'b0;
        repeat (n - 1) @(negedge clk);
    endtask

    task automatic offer(input logic [7:0] b);
        if (!no_idle && $urandom_range(0, 5) == 0)
            idle_sender($urandom_range(1, 3));
        send_byte(b);
        bytes_sent++;
    endtask

    task automatic drain();
        @(negedge clk);
        in_valid <= 1'b0;
        while (board.pending() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_channel(input logic [3:0] ch);
        @(negedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= ch;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
        board.set_channel(ch);
    endtask

    task automatic send_message(input logic [3:0] rx);
        int         roll;
        int         ndata;
        logic [3:0] kind;
        logic [3:0] ch;
        roll = $urandom_range(0, 99);
        if (roll < 8)
        begin
            offer(8'($urandom_range(0, 255)));
            last_status = 8'h00;
        end
        else if (roll < 12)
            offer(REALTIME_MASK | 8'($urandom_range(0, 7)));
        else if (roll < 15)
        begin
            offer(SYSTEM_MASK | 8'($urandom_range(0, 7)));
            last_status = 8'h00;
        end
        else
        begin
            if (last_status == 8'h00 || $urandom_range(0, 3) != 0)
            begin
                kind = 4'($urandom_range(KIND_NOTE_OFF, KIND_PITCH_BEND));
                ch   = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(0, 15)) : rx;
                last_status = {kind, ch};
                offer(last_status);
            end
            ndata = (last_status[7:4] == KIND_PROG_CHANGE
                     || last_status[7:4] == KIND_CHAN_PRESSURE) ? 1 : 2;
            // truncate now and then
            if ($urandom_range(0, 19) == 0)
                ndata--;
            for (int i = 0; i < ndata; i++)
            begin
                if ($urandom_range(0, 19) == 0)
                    offer(REALTIME_MASK | 8'($urandom_range(0, 7)));
                if (i == 1 && last_status[7:4] == KIND_NOTE_ON && $urandom_range(0, 3) == 0)
                    offer(8'h00);
                else
                    offer(8'($urandom_range(0, 127)));
            end
        end
    endtask

    logic [7:0] directed_bytes[] = '{
        8'h00, 8'h90, 8'h00, 8'h7F, 8'h00, 8'h00, 8'hF8, 8'h7F,
        8'hFF, 8'h40, 8'hC0, 8'h05, 8'h06, 8'hD0, 8'h7F, 8'hF0,
        8'h12, 8'hB1, 8'h01, 8'h02, 8'hE0, 8'h7F, 8'h00, 8'hF7
    };

    initial
    begin
        logic [3:0] ch;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (directed_bytes[i])
            offer(directed_bytes[i]);

        for (int p = 0; p < PHASES; p++)
        begin
            drain();
            if (p == 0 || p == 6)
                ch = 4'hF;
            else if (p == 1)
                ch = 4'h0;
            else
                ch = 4'($urandom_range(0, 15));
            write_channel(ch);
            no_idle = (p == PHASES - 1);
            // hold the output long enough for the input to back up
            if (p == 1)
            begin
                long_hold_req = 1'b1;
                repeat (40) send_byte(REALTIME_MASK | 8'($urandom_range(0, 7)));
            end
            bytes_sent = 0;
            while (bytes_sent < PHASE_BYTES)
                send_message(ch);
        end

        drain();
        repeat (10) @(posedge clk);
        if (board.errors == 0 && board.pending() == 0)
            $display("midi_stream_parser regression: pass");
        else
            $display("midi_stream_parser regression: fail");
        $finish;
    end

endmodule
